>>> hdl/afk_pkg.sv
package afk_pkg;

  localparam int AngW   = 16;
  localparam int TrigW  = 18;
  localparam int PosW   = 19;
  localparam int LinkW  = 16;
  localparam int CordW  = 34;
  localparam int ZW     = 26;
  localparam int NSteps = 18;
  localparam int NJoint = 7;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  // fold register, one register per micro-rotation, output register
  localparam int CordLat = NSteps + 2;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [PosW-1:0]  RotLim     = 19'sd65536;
  localparam logic signed [PosW-1:0]  PosLim     = 19'sd131072;
  localparam logic [LinkW-1:0]        UpperReset = 16'd27984;
  localparam logic [LinkW-1:0]        LowerReset = 16'd27525;

  typedef enum logic {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_reg_e;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [PosW-1:0]  pos_t;

  // sines and cosines of all joints, joint k in slice k
  typedef struct packed {
    logic [NJoint-1:0][TrigW-1:0] sn;
    logic [NJoint-1:0][TrigW-1:0] cs;
  } trig_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [ZW-1:0] atan_step(input int idx);
    logic signed [ZW-1:0] r;
    begin
      case (idx)
        0:       r = 26'sd2097152;
        1:       r = 26'sd1238021;
        2:       r = 26'sd654136;
        3:       r = 26'sd332050;
        4:       r = 26'sd166669;
        5:       r = 26'sd83416;
        6:       r = 26'sd41718;
        7:       r = 26'sd20860;
        8:       r = 26'sd10430;
        9:       r = 26'sd5215;
        10:      r = 26'sd2608;
        11:      r = 26'sd1304;
        12:      r = 26'sd652;
        13:      r = 26'sd326;
        14:      r = 26'sd163;
        15:      r = 26'sd81;
        16:      r = 26'sd41;
        17:      r = 26'sd20;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // (p*q + u*v), rounded to Q16 and clamped to +-lim
  function automatic pos_t dot(input trig_t p, input trig_t q, input trig_t u,
                               input trig_t v, input pos_t lim);
    logic signed [2*TrigW:0] acc;
    logic signed [2*TrigW:0] sh;
    pos_t r;
    begin
      acc = p * q + u * v + 37'sd32768;
      sh  = acc >>> 16;
      if (sh > lim) begin
        r = lim;
      end else if (sh < -lim) begin
        r = -lim;
      end else begin
        r = sh[PosW-1:0];
      end
      return r;
    end
  endfunction

  function automatic trig_t dot_r(input trig_t p, input trig_t q, input trig_t u,
                                  input trig_t v);
    pos_t r;
    begin
      r = dot(p, q, u, v, RotLim);
      return r[TrigW-1:0];
    end
  endfunction

endpackage

>>> hdl/afk_cordic.sv
module afk_cordic (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [afk_pkg::AngW-1:0]  ang_i,
  output logic signed [afk_pkg::TrigW-1:0] sin_o,
  output logic signed [afk_pkg::TrigW-1:0] cos_o
);
  import afk_pkg::*;

  logic signed [CordW-1:0] x_q [0:NSteps];
  logic signed [CordW-1:0] y_q [0:NSteps];
  logic signed [ZW-1:0]    z_q [0:NSteps];
  logic                    flip_q [0:NSteps];

  logic signed [AngW:0] fold;
  logic                 flip_d;

  always_comb begin
    fold   = {ang_i[AngW-1], ang_i};
    flip_d = 1'b0;
    if (fold > 17'sd16384) begin
      fold   = fold - 17'sd32768;
      flip_d = 1'b1;
    end else if (fold < -17'sd16384) begin
      fold   = fold + 17'sd32768;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= ZW'({{(ZW-AngW-1){fold[AngW]}}, fold} <<< 8);
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < NSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_step(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_step(i);
        end
      end
    end
  end

  logic signed [CordW-1:0] xr, yr;
  trig_t cos_d, sin_d;

  always_comb begin
    xr = (x_q[NSteps] + 34'sd8192) >>> 14;
    yr = (y_q[NSteps] + 34'sd8192) >>> 14;
    if (xr > 34'sd65536)       cos_d = 18'sd65536;
    else if (xr < -34'sd65536) cos_d = -18'sd65536;
    else                       cos_d = xr[TrigW-1:0];
    if (yr > 34'sd65536)       sin_d = 18'sd65536;
    else if (yr < -34'sd65536) sin_d = -18'sd65536;
    else                       sin_d = yr[TrigW-1:0];
    if (flip_q[NSteps]) begin
      cos_d = -cos_d;
      sin_d = -sin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end

endmodule

>>> hdl/afk_front.sv
module afk_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [afk_pkg::NJoint-1:0][afk_pkg::AngW-1:0] ang_i,
  output logic                   valid_o,
  output afk_pkg::trig_set_t     trig_o
);
  import afk_pkg::*;

  logic [CordLat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CordLat-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[CordLat-1];

  for (genvar k = 0; k < NJoint; k++) begin : g_joint
    trig_t sn, cs;
    afk_cordic u_cordic (
      .clk_i (clk_i),
      .en_i  (en_i),
      .ang_i ($signed(ang_i[k])),
      .sin_o (sn),
      .cos_o (cs)
    );
    assign trig_o.sn[k] = sn;
    assign trig_o.cs[k] = cs;
  end

endmodule

>>> hdl/afk_queue.sv
module afk_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  afk_pkg::trig_set_t data_i,
  input  logic               pop_i,
  output afk_pkg::trig_set_t data_o,
  output afk_pkg::q_stat_t   stat_o
);
  import afk_pkg::*;

  trig_set_t          mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> hdl/afk_back.sv
module afk_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           avail_i,
  input  afk_pkg::trig_set_t             trig_i,
  output logic                           pop_o,
  input  logic [afk_pkg::LinkW-1:0]      upper_i,
  input  logic [afk_pkg::LinkW-1:0]      lower_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic signed [afk_pkg::TrigW-1:0] col0_o [3],
  output logic signed [afk_pkg::TrigW-1:0] col1_o [3],
  output logic signed [afk_pkg::TrigW-1:0] col2_o [3],
  output logic signed [afk_pkg::PosW-1:0]  pos_o [3]
);
  import afk_pkg::*;

  logic       en;
  logic [5:0] v_q;

  assign en      = !v_q[5] || !stall_i;
  assign pop_o   = en && avail_i;
  assign valid_o = v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:0], avail_i};
    end
  end

  trig_t sn [NJoint];
  trig_t cs [NJoint];
  for (genvar k = 0; k < NJoint; k++) begin : g_unpack
    assign sn[k] = $signed(trig_i.sn[k]);
    assign cs[k] = $signed(trig_i.cs[k]);
  end

  // stage 1: products of joints one to three
  trig_t c1c2_q, s1c2_q, a2_q, d2_q;
  trig_t b1_q [3];
  trig_t s1_sn_q [NJoint];
  trig_t s1_cs_q [NJoint];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1c2_q  <= dot_r(cs[0], cs[1], '0, '0);
      s1c2_q  <= dot_r(sn[0], cs[1], '0, '0);
      b1_q[0] <= dot_r(cs[0], sn[1], '0, '0);
      b1_q[1] <= dot_r(sn[0], sn[1], '0, '0);
      b1_q[2] <= cs[1];
      a2_q    <= -dot_r(sn[1], cs[2], '0, '0);
      d2_q    <= dot_r(sn[1], sn[2], '0, '0);
      s1_sn_q <= sn;
      s1_cs_q <= cs;
    end
  end

  // stage 2: rows of the first three joints
  trig_t a_q [3], b2_q [3], d_q [3];
  trig_t s2_sn_q [NJoint];
  trig_t s2_cs_q [NJoint];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0]  <= dot_r(c1c2_q, s1_cs_q[2], -s1_sn_q[0], s1_sn_q[2]);
      d_q[0]  <= -dot_r(c1c2_q, s1_sn_q[2], s1_sn_q[0], s1_cs_q[2]);
      a_q[1]  <= dot_r(s1_cs_q[0], s1_sn_q[2], s1c2_q, s1_cs_q[2]);
      d_q[1]  <= dot_r(s1_cs_q[0], s1_cs_q[2], -s1c2_q, s1_sn_q[2]);
      a_q[2]  <= a2_q;
      d_q[2]  <= d2_q;
      b2_q    <= b1_q;
      s2_sn_q <= s1_sn_q;
      s2_cs_q <= s1_cs_q;
    end
  end

  trig_t e_q [3], f3_q [3], b3_q [3], d3_q [3];
  trig_t g_q [3], h_q [3], f4_q [3], b4_q [3];
  trig_t m_q [3], g5_q [3], c2_q [3];
  pos_t  p5_q [3];
  trig_t s3_sn_q [NJoint], s3_cs_q [NJoint];
  trig_t s4_sn_q [NJoint], s4_cs_q [NJoint];
  trig_t s5_sn_q [NJoint], s5_cs_q [NJoint];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sn_q <= s2_sn_q;
      s3_cs_q <= s2_cs_q;
      s4_sn_q <= s3_sn_q;
      s4_cs_q <= s3_cs_q;
      s5_sn_q <= s4_sn_q;
      s5_cs_q <= s4_cs_q;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en) begin
        // joint four
        e_q[r]  <= dot_r(a_q[r], s2_cs_q[3], -b2_q[r], s2_sn_q[3]);
        f3_q[r] <= dot_r(a_q[r], s2_sn_q[3], b2_q[r], s2_cs_q[3]);
        b3_q[r] <= b2_q[r];
        d3_q[r] <= d_q[r];
        // joint five
        g_q[r]  <= dot_r(e_q[r], s3_cs_q[4], d3_q[r], s3_sn_q[4]);
        h_q[r]  <= dot_r(e_q[r], s3_sn_q[4], -d3_q[r], s3_cs_q[4]);
        f4_q[r] <= f3_q[r];
        b4_q[r] <= b3_q[r];
        // joint six and translation
        m_q[r]  <= dot_r(f4_q[r], s4_sn_q[5], h_q[r], s4_cs_q[5]);
        c2_q[r] <= dot_r(-h_q[r], s4_sn_q[5], f4_q[r], s4_cs_q[5]);
        p5_q[r] <= dot($signed({2'b00, lower_i}), f4_q[r],
                       $signed({2'b00, upper_i}), b4_q[r], PosLim);
        g5_q[r] <= g_q[r];
        // joint seven, output register
        col0_o[r] <= dot_r(g5_q[r], s5_sn_q[6], m_q[r], s5_cs_q[6]);
        col1_o[r] <= dot_r(-m_q[r], s5_sn_q[6], g5_q[r], s5_cs_q[6]);
        col2_o[r] <= c2_q[r];
        pos_o[r]  <= p5_q[r];
      end
    end
  end

endmodule

>>> hdl/arm_forward_kinematics_7dof.sv
// channel   direction  handshake                 beat
// in        sink       in_valid_i / in_stall_o   seven 16-bit joint angles
// out       source     out_valid_o / out_stall_i nine Q1.16 rotation, three Q2.16 position
// cfg       sink       cfg_we_i                  link length by cfg_addr_i
//
// One beat per cycle while neither side stalls. 27 register stages: 20 in the CORDIC
// front (fold register, one per micro-rotation, output register), one queue slot, 6 in
// the rotation chain. The first loads on the accepting edge. The CORDIC front freezes
// while the queue is full; the back freezes while the output register holds an
// unaccepted beat. Reset clears valids and queue pointers and loads the default link
// lengths.
module arm_forward_kinematics_7dof (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] angle_one_i,
  input  logic signed [15:0] angle_two_i,
  input  logic signed [15:0] angle_three_i,
  input  logic signed [15:0] angle_four_i,
  input  logic signed [15:0] angle_five_i,
  input  logic signed [15:0] angle_six_i,
  input  logic signed [15:0] angle_seven_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [17:0] rot_r0_c0_o,
  output logic signed [17:0] rot_r1_c0_o,
  output logic signed [17:0] rot_r2_c0_o,
  output logic signed [17:0] rot_r0_c1_o,
  output logic signed [17:0] rot_r1_c1_o,
  output logic signed [17:0] rot_r2_c1_o,
  output logic signed [17:0] rot_r0_c2_o,
  output logic signed [17:0] rot_r1_c2_o,
  output logic signed [17:0] rot_r2_c2_o,
  output logic signed [18:0] pos_x_o,
  output logic signed [18:0] pos_y_o,
  output logic signed [18:0] pos_z_o
);
  import afk_pkg::*;

  logic [LinkW-1:0] upper_q, lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UpperReset;
      lower_q <= LowerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_UPPER: upper_q <= cfg_wdata_i;
        REG_LOWER: lower_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  logic [NJoint-1:0][AngW-1:0] ang;
  assign ang = {angle_seven_i, angle_six_i, angle_five_i, angle_four_i,
                angle_three_i, angle_two_i, angle_one_i};

  q_stat_t   q_stat;
  trig_set_t front_trig, q_trig;
  logic      front_valid, front_en, q_pop;

  assign front_en   = !q_stat.full;
  assign in_stall_o = q_stat.full;

  afk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (front_en),
    .valid_i (in_valid_i),
    .ang_i   (ang),
    .valid_o (front_valid),
    .trig_o  (front_trig)
  );

  afk_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid && front_en),
    .data_i (front_trig),
    .pop_i  (q_pop),
    .data_o (q_trig),
    .stat_o (q_stat)
  );

  trig_t c0 [3], c1 [3], c2 [3];
  pos_t  p [3];

  afk_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!q_stat.empty),
    .trig_i  (q_trig),
    .pop_o   (q_pop),
    .upper_i (upper_q),
    .lower_i (lower_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .col0_o  (c0),
    .col1_o  (c1),
    .col2_o  (c2),
    .pos_o   (p)
  );

  assign rot_r0_c0_o = c0[0];
  assign rot_r1_c0_o = c0[1];
  assign rot_r2_c0_o = c0[2];
  assign rot_r0_c1_o = c1[0];
  assign rot_r1_c1_o = c1[1];
  assign rot_r2_c1_o = c1[2];
  assign rot_r0_c2_o = c2[0];
  assign rot_r1_c2_o = c2[1];
  assign rot_r2_c2_o = c2[2];
  assign pos_x_o     = p[0];
  assign pos_y_o     = p[1];
  assign pos_z_o     = p[2];

`ifndef SYNTHESIS
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty)) else $error("queue full and empty");

  a_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rot_r0_c0_o <= 18'sd65536) && (rot_r0_c0_o >= -18'sd65536))
    else $error("rotation out of range");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pos_z_o <= 19'sd131072) && (pos_z_o >= -19'sd131072))
    else $error("position out of range");
`endif

endmodule
